// File: src/bms_pkg.sv
// Shared types, constants and helpers for the batch statistics unit.
package bms_pkg;

  localparam logic [16:0] MAX_TRIALS = 17'd65536;

  localparam logic [7:0] MUL_STEPS  = 8'd64;
  localparam logic [7:0] DIV_STEPS  = 8'd128;
  localparam logic [7:0] SQRT_STEPS = 8'd32;

  localparam logic [63:0] POOL_SCALE = 64'd6553600;
  localparam logic [63:0] CI_RECIP   = 64'd1407374883554;
  localparam logic [63:0] SQRT_TOP   = 64'h4000_0000_0000_0000;

  localparam logic [3:0] STAT_COUNT    = 4'd0;
  localparam logic [3:0] STAT_MEAN_FIN = 4'd1;
  localparam logic [3:0] STAT_BUST     = 4'd2;
  localparam logic [3:0] STAT_WAGERED  = 4'd3;
  localparam logic [3:0] STAT_POOLED   = 4'd4;
  localparam logic [3:0] STAT_PRF_MEAN = 4'd5;
  localparam logic [3:0] STAT_RET_MEAN = 4'd10;
  localparam logic [3:0] STAT_RET_HI   = 4'd14;

  typedef struct packed {
    logic signed [39:0] final_amount;
    logic signed [39:0] start_amount;
    logic [38:0]        wagered_amount;
    logic               went_bust;
    logic signed [23:0] profit_pct;
    logic signed [23:0] wager_return_pct;
    logic               last_trial;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         stat_code;
    logic signed [63:0] stat_value;
    logic               last_stat;
  } out_item_t;

  typedef enum logic [1:0] {
    EOP_MUL,
    EOP_DIV,
    EOP_SQRT
  } eng_op_t;

  typedef struct packed {
    logic          start;
    eng_op_t       op;
    logic [127:0]  a;
    logic [63:0]   b;
  } eng_req_t;

  typedef struct packed {
    logic load;
    logic clear;
  } acc_ctl_t;

  typedef struct packed {
    logic [16:0]       count;
    logic [55:0]       final_sum;
    logic [56:0]       profit_sum;
    logic [55:0]       wager_sum;
    logic [16:0]       bust_count;
    logic [1:0][39:0]  pct_sum;
    logic [1:0][62:0]  pct_sq;
  } acc_sums_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ACC2,
    ST_E_CNT,
    ST_D_MFIN,
    ST_E_MFIN,
    ST_D_BUST,
    ST_E_BUST,
    ST_E_WAG,
    ST_M_POOL,
    ST_D_POOL,
    ST_E_POOL,
    ST_M_NN1,
    ST_M_NNN1,
    ST_D_MEAN,
    ST_E_MEAN,
    ST_M_NQ,
    ST_M_SS,
    ST_D_SD,
    ST_Q_SD,
    ST_D_SE,
    ST_Q_SE,
    ST_E_SD,
    ST_E_SE,
    ST_D_HALF,
    ST_E_LO,
    ST_E_HI
  } state_t;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [63:0] neg_if(input logic [63:0] v, input logic neg);
    return neg ? (~v + 64'd1) : v;
  endfunction

endpackage

// File: src/bms_engine.sv
// Shared bit-serial multiply, divide and square-root unit.
module bms_engine
  import bms_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  eng_req_t     req,
  output logic         done,
  output logic [127:0] res
);

  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  eng_op_t      op_r, op_nxt;
  logic [7:0]   cnt_r, cnt_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [127:0] x_r, x_nxt;
  logic [63:0]  y_r, y_nxt;
  logic [63:0]  q_r, q_nxt;
  logic [63:0]  r_r, r_nxt;
  logic         over_r, over_nxt;

  logic [63:0]  rn;
  logic [63:0]  qs;
  logic [63:0]  st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= EOP_MUL;
      cnt_r  <= 8'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r  <= acc_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    q_r    <= q_nxt;
    r_r    <= r_nxt;
    over_r <= over_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    over_nxt = over_r;
    rn       = {r_r[62:0], x_r[127]};
    qs       = {q_r[62:0], 1'b0};
    st       = q_r + y_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      acc_nxt  = '0;
      q_nxt    = '0;
      r_nxt    = '0;
      over_nxt = 1'b0;
      x_nxt    = req.a;
      y_nxt    = req.b;
      case (req.op)
        EOP_MUL:  cnt_nxt = MUL_STEPS;
        EOP_DIV:  cnt_nxt = DIV_STEPS;
        EOP_SQRT: begin
          cnt_nxt = SQRT_STEPS;
          y_nxt   = SQRT_TOP;
        end
        default:  cnt_nxt = MUL_STEPS;
      endcase
    end else if (busy_r) begin
      case (op_r)
        EOP_MUL: begin
          if (y_r[0]) begin
            acc_nxt = acc_r + x_r;
          end
          x_nxt = {x_r[126:0], 1'b0};
          y_nxt = {1'b0, y_r[63:1]};
        end
        EOP_DIV: begin
          x_nxt    = {x_r[126:0], 1'b0};
          over_nxt = over_r | q_r[63];
          if (rn >= y_r) begin
            r_nxt = rn - y_r;
            q_nxt = qs | 64'd1;
          end else begin
            r_nxt = rn;
            q_nxt = qs;
          end
        end
        EOP_SQRT: begin
          if (x_r[63:0] >= st) begin
            x_nxt = {x_r[127:64], x_r[63:0] - st};
            q_nxt = {1'b0, q_r[63:1]} + y_r;
          end else begin
            q_nxt = {1'b0, q_r[63:1]};
          end
          y_nxt = {2'b00, y_r[63:2]};
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      cnt_nxt = cnt_r - 8'd1;
      if (cnt_r == 8'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done = done_r;

  always_comb begin
    case (op_r)
      EOP_MUL:  res = acc_r;
      EOP_DIV:  res = {64'd0, over_r ? {64{1'b1}} : q_r};
      EOP_SQRT: res = {64'd0, q_r};
      default:  res = acc_r;
    endcase
  end

endmodule

// File: src/bms_accum.sv
// Trial accumulators with a shared squaring multiplier.
module bms_accum
  import bms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  acc_ctl_t  ctl,
  input  in_item_t  item,
  output acc_sums_t sums
);

  acc_sums_t   sums_r;
  logic        phase_r;
  logic        take_r;
  logic [23:0] mag1_r;

  logic        take;
  logic [23:0] mag0;
  logic [23:0] mag1;
  logic [23:0] mul_in;
  logic [47:0] sq;

  assign take   = sums_r.count < MAX_TRIALS;
  assign mag0   = item.profit_pct[23] ? (~item.profit_pct + 24'd1) : item.profit_pct;
  assign mag1   = item.wager_return_pct[23] ?
                  (~item.wager_return_pct + 24'd1) : item.wager_return_pct;
  assign mul_in = phase_r ? mag1_r : mag0;
  assign sq     = mul_in * mul_in;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      sums_r  <= '0;
      phase_r <= 1'b0;
      take_r  <= 1'b0;
    end else if (ctl.load) begin
      phase_r <= 1'b1;
      take_r  <= take;
      if (take) begin
        sums_r.count      <= sums_r.count + 17'd1;
        sums_r.final_sum  <= sums_r.final_sum + {{16{item.final_amount[39]}},
                                                 item.final_amount};
        sums_r.profit_sum <= sums_r.profit_sum
                             + {{17{item.final_amount[39]}}, item.final_amount}
                             - {{17{item.start_amount[39]}}, item.start_amount};
        sums_r.wager_sum  <= sums_r.wager_sum + {17'd0, item.wagered_amount};
        sums_r.bust_count <= sums_r.bust_count + {16'd0, item.went_bust};
        sums_r.pct_sum[0] <= sums_r.pct_sum[0] + {{16{item.profit_pct[23]}},
                                                  item.profit_pct};
        sums_r.pct_sum[1] <= sums_r.pct_sum[1] + {{16{item.wager_return_pct[23]}},
                                                  item.wager_return_pct};
        sums_r.pct_sq[0]  <= sums_r.pct_sq[0] + {15'd0, sq};
      end
    end else if (phase_r) begin
      phase_r <= 1'b0;
      if (take_r) begin
        sums_r.pct_sq[1] <= sums_r.pct_sq[1] + {15'd0, sq};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mag1_r <= mag1;
    end
  end

  assign sums = sums_r;

endmodule

// File: src/batch_mean_stddev_ci_stats_unit.sv
// Top level: batch trial statistics with sequencer and result register.
//
// Usage:
//   in_valid/in_ready/in_data carries one trial record per word. The two
//   percent squares share one multiplier, so in_ready drops for the cycle
//   after each accepted word.
//   A word with last_trial set closes the batch. The block then drops in_ready
//   and runs a sequencer over one shared bit-serial unit (64-step multiply,
//   128-step divide, 32-step root) to produce 15 result words on
//   out_valid/out_ready/out_data, codes 0 to 14, last_stat on code 14.
//   The divides dominate the run. After code 14 is loaded into the output
//   register, all sums clear and in_ready returns.
//   A stalled receiver holds the output register; the sequencer waits for it
//   before loading the next word, so no word is lost or repeated.
//   Reset (rst_n low, synchronous) clears all sums, the sequencer and the
//   output valid.
module batch_mean_stddev_ci_stats_unit
  import bms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  state_t       state_r, state_nxt;
  logic         issued_r, issued_nxt;
  logic         p_r, p_nxt;
  logic         last_r, last_nxt;
  logic [63:0]  val_r, val_nxt;
  logic [63:0]  mean_r, mean_nxt;
  logic [63:0]  sd_r, sd_nxt;
  logic [63:0]  se_r, se_nxt;
  logic [63:0]  nn1_r, nn1_nxt;
  logic [63:0]  nnn1_r, nnn1_nxt;
  logic [127:0] tmp_r, tmp_nxt;
  logic [127:0] dw_r, dw_nxt;
  logic         out_valid_r, out_valid_nxt;
  out_item_t    out_data_r, out_data_nxt;

  acc_ctl_t     acc_ctl;
  acc_sums_t    sums;
  eng_req_t     req;
  logic         eng_done;
  logic [127:0] eng_res;

  logic [63:0]  n64;
  logic [63:0]  fin64;
  logic [63:0]  prof64;
  logic [63:0]  ps64;
  logic [63:0]  ps_mag;
  logic [62:0]  pq;
  logic [63:0]  q64;
  logic [63:0]  se196;
  logic [3:0]   pbase;
  logic         out_free;
  logic         emit;
  logic [3:0]   emit_code;
  logic [63:0]  emit_val;
  logic         emit_last;
  logic         fire;
  logic         accept;

  bms_accum u_accum (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (acc_ctl),
    .item (in_data),
    .sums (sums)
  );

  bms_engine u_engine (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .done (eng_done),
    .res  (eng_res)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign n64    = {47'd0, sums.count};
  assign fin64  = {{8{sums.final_sum[55]}}, sums.final_sum};
  assign prof64 = {{7{sums.profit_sum[56]}}, sums.profit_sum};
  assign ps64   = {{24{sums.pct_sum[p_r][39]}}, sums.pct_sum[p_r]};
  assign ps_mag = mag64(ps64);
  assign pq     = sums.pct_sq[p_r];
  assign q64    = eng_res[63:0];
  assign se196  = {se_r[56:0], 7'd0} + {se_r[57:0], 6'd0} + {se_r[61:0], 2'd0};
  assign pbase  = p_r ? STAT_RET_MEAN : STAT_PRF_MEAN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      p_r         <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      p_r         <= p_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    val_r      <= val_nxt;
    mean_r     <= mean_nxt;
    sd_r       <= sd_nxt;
    se_r       <= se_nxt;
    nn1_r      <= nn1_nxt;
    nnn1_r     <= nnn1_nxt;
    tmp_r      <= tmp_nxt;
    dw_r       <= dw_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    p_nxt         = p_r;
    last_nxt      = last_r;
    val_nxt       = val_r;
    mean_nxt      = mean_r;
    sd_nxt        = sd_r;
    se_nxt        = se_r;
    nn1_nxt       = nn1_r;
    nnn1_nxt      = nnn1_r;
    tmp_nxt       = tmp_r;
    dw_nxt        = dw_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    acc_ctl       = '0;
    req           = '0;
    req.op        = EOP_MUL;
    emit          = 1'b0;
    emit_code     = STAT_COUNT;
    emit_val      = 64'd0;
    emit_last     = 1'b0;
    fire          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          acc_ctl.load = 1'b1;
          last_nxt     = in_data.last_trial;
          state_nxt    = ST_ACC2;
        end
      end
      ST_ACC2: begin
        p_nxt     = 1'b0;
        state_nxt = last_r ? ST_E_CNT : ST_IDLE;
      end
      ST_E_CNT: begin
        emit      = 1'b1;
        emit_code = STAT_COUNT;
        emit_val  = n64;
        if (out_free) begin
          state_nxt = ST_D_MFIN;
        end
      end
      ST_D_MFIN: begin
        req.op = EOP_DIV;
        req.a  = {56'd0, mag64(fin64), 8'd0};
        req.b  = n64;
        fire   = 1'b1;
        if (issued_r && eng_done) begin
          val_nxt   = neg_if(q64, fin64[63]);
          state_nxt = ST_E_MFIN;
        end
      end
      ST_E_MFIN: begin
        emit      = 1'b1;
        emit_code = STAT_MEAN_FIN;
        emit_val  = val_r;
        if (out_free) begin
          state_nxt = ST_D_BUST;
        end
      end
      ST_D_BUST: begin
        req.op = EOP_DIV;
        req.a  = {95'd0, sums.bust_count, 16'd0};
        req.b  = n64;
        fire   = 1'b1;
        if (issued_r && eng_done) begin
          val_nxt   = q64;
          state_nxt = ST_E_BUST;
        end
      end
      ST_E_BUST: begin
        emit      = 1'b1;
        emit_code = STAT_BUST;
        emit_val  = val_r;
        if (out_free) begin
          state_nxt = ST_E_WAG;
        end
      end
      ST_E_WAG: begin
        emit      = 1'b1;
        emit_code = STAT_WAGERED;
        emit_val  = {sums.wager_sum, 8'd0};
        if (out_free) begin
          if (sums.wager_sum == 56'd0) begin
            val_nxt   = 64'd0;
            state_nxt = ST_E_POOL;
          end else begin
            state_nxt = ST_M_POOL;
          end
        end
      end
      ST_M_POOL: begin
        req.op = EOP_MUL;
        req.a  = {64'd0, mag64(prof64)};
        req.b  = POOL_SCALE;
        fire   = 1'b1;
        if (issued_r && eng_done) begin
          tmp_nxt   = eng_res;
          state_nxt = ST_D_POOL;
        end
      end
      ST_D_POOL: begin
        req.op = EOP_DIV;
        req.a  = tmp_r;
        req.b  = {8'd0, sums.wager_sum};
        fire   = 1'b1;
        if (issued_r && eng_done) begin
          if (prof64[63]) begin
            val_nxt = q64[63] ? {1'b1, 63'd0} : neg_if(q64, 1'b1);
          end else begin
            val_nxt = q64[63] ? {1'b0, {63{1'b1}}} : q64;
          end
          state_nxt = ST_E_POOL;
        end
      end
      ST_E_POOL: begin
        emit      = 1'b1;
        emit_code = STAT_POOLED;
        emit_val  = val_r;
        if (out_free) begin
          state_nxt = (sums.count > 17'd1) ? ST_M_NN1 : ST_D_MEAN;
        end
      end
      ST_M_NN1: begin
        req.op = EOP_MUL;
        req.a  = {64'd0, n64};
        req.b  = n64 - 64'd1;
        fire   = 1'b1;
        if (issued_r && eng_done) begin
          nn1_nxt   = q64;
          state_nxt = ST_M_NNN1;
        end
      end
      ST_M_NNN1: begin
        req.op = EOP_MUL;
        req.a  = {64'd0, nn1_r};
        req.b  = n64;
        fire   = 1'b1;
        if (issued_r && eng_done) begin
          nnn1_nxt  = q64;
          state_nxt = ST_D_MEAN;
        end
      end
      ST_D_MEAN: begin
        req.op = EOP_DIV;
        req.a  = {56'd0, ps_mag, 8'd0};
        req.b  = n64;
        fire   = 1'b1;
        if (issued_r && eng_done) begin
          mean_nxt  = neg_if(q64, ps64[63]);
          state_nxt = ST_E_MEAN;
        end
      end
      ST_E_MEAN: begin
        emit      = 1'b1;
        emit_code = pbase;
        emit_val  = mean_r;
        if (out_free) begin
          if (sums.count > 17'd1) begin
            state_nxt = ST_M_NQ;
          end else begin
            sd_nxt    = 64'd0;
            se_nxt    = 64'd0;
            state_nxt = ST_E_SD;
          end
        end
      end
      ST_M_NQ: begin
        req.op = EOP_MUL;
        req.a  = {65'd0, pq};
        req.b  = n64;
        fire   = 1'b1;
        if (issued_r && eng_done) begin
          tmp_nxt   = eng_res;
          state_nxt = ST_M_SS;
        end
      end
      ST_M_SS: begin
        req.op = EOP_MUL;
        req.a  = {64'd0, ps_mag};
        req.b  = ps_mag;
        fire   = 1'b1;
        if (issued_r && eng_done) begin
          dw_nxt    = (tmp_r >= eng_res) ? {tmp_r[111:0] - eng_res[111:0], 16'd0}
                                         : 128'd0;
          state_nxt = ST_D_SD;
        end
      end
      ST_D_SD: begin
        req.op = EOP_DIV;
        req.a  = dw_r;
        req.b  = nn1_r;
        fire   = 1'b1;
        if (issued_r && eng_done) begin
          val_nxt   = q64;
          state_nxt = ST_Q_SD;
        end
      end
      ST_Q_SD: begin
        req.op = EOP_SQRT;
        req.a  = {64'd0, val_r};
        fire   = 1'b1;
        if (issued_r && eng_done) begin
          sd_nxt    = q64;
          state_nxt = ST_D_SE;
        end
      end
      ST_D_SE: begin
        req.op = EOP_DIV;
        req.a  = dw_r;
        req.b  = nnn1_r;
        fire   = 1'b1;
        if (issued_r && eng_done) begin
          val_nxt   = q64;
          state_nxt = ST_Q_SE;
        end
      end
      ST_Q_SE: begin
        req.op = EOP_SQRT;
        req.a  = {64'd0, val_r};
        fire   = 1'b1;
        if (issued_r && eng_done) begin
          se_nxt    = q64;
          state_nxt = ST_E_SD;
        end
      end
      ST_E_SD: begin
        emit      = 1'b1;
        emit_code = pbase + 4'd1;
        emit_val  = sd_r;
        if (out_free) begin
          state_nxt = ST_E_SE;
        end
      end
      ST_E_SE: begin
        emit      = 1'b1;
        emit_code = pbase + 4'd2;
        emit_val  = se_r;
        if (out_free) begin
          state_nxt = ST_D_HALF;
        end
      end
      ST_D_HALF: begin
        req.op = EOP_MUL;
        req.a  = {64'd0, se196};
        req.b  = CI_RECIP;
        fire   = 1'b1;
        if (issued_r && eng_done) begin
          val_nxt   = eng_res[110:47];
          state_nxt = ST_E_LO;
        end
      end
      ST_E_LO: begin
        emit      = 1'b1;
        emit_code = pbase + 4'd3;
        emit_val  = mean_r - val_r;
        if (out_free) begin
          state_nxt = ST_E_HI;
        end
      end
      ST_E_HI: begin
        emit      = 1'b1;
        emit_code = pbase + 4'd4;
        emit_val  = mean_r + val_r;
        emit_last = p_r;
        if (out_free) begin
          if (p_r) begin
            acc_ctl.clear = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            p_nxt     = 1'b1;
            state_nxt = ST_D_MEAN;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fire) begin
      if (!issued_r) begin
        req.start  = 1'b1;
        issued_nxt = 1'b1;
      end else if (eng_done) begin
        issued_nxt = 1'b0;
      end
    end

    if (emit && out_free) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.stat_code  = emit_code;
      out_data_nxt.stat_value = emit_val;
      out_data_nxt.last_stat  = emit_last;
    end
  end

endmodule

// File: src/bms_checker.sv
// Port-level checks for the batch statistics unit, bound to the top level.
module bms_checker
  import bms_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_last_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_stat |-> out_data.stat_code == STAT_RET_HI)
    else $error("last_stat on wrong code");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.stat_code <= STAT_RET_HI)
    else $error("stat_code out of range");

  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input word taken in back-to-back cycles");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear the block");

endmodule

bind batch_mean_stddev_ci_stats_unit bms_checker u_bms_checker (.*);
